// ===== hw/rtl/xbu_pkg.sv =====
// Shared types, codes and sizes of the x86 branch unit.
package xbu_pkg;

  // Return stack size and the widths that follow from it.
  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned BANK_AW     = IDX_W - 1;
  localparam int unsigned BANK_DEPTH  = (STACK_DEPTH + 1) / 2;

  // Instruction classes.
  typedef enum logic [3:0] {
    FN_JCC,
    FN_JMP_REL8,
    FN_JMP_REL16,
    FN_JMP_FAR,
    FN_LOOP,
    FN_CALL_REL16,
    FN_CALL_FAR,
    FN_RET_NEAR,
    FN_RET_FAR,
    FN_ADVANCE
  } func_e;

  // Error codes reported with each result.
  typedef enum logic [1:0] {
    ERR_OK,
    ERR_OVERFLOW,
    ERR_UNDERFLOW
  } err_e;

  // Condition groups; the low bit of the condition code inverts the group.
  typedef enum logic [2:0] {
    CC_O,
    CC_C,
    CC_Z,
    CC_BE,
    CC_S,
    CC_P,
    CC_L,
    CC_LE
  } ccgrp_e;

  // One decoded instruction.
  typedef struct packed {
    logic [3:0]         func;
    logic [3:0]         cond;
    logic signed [15:0] disp;
    logic [15:0]        target_offset;
    logic [15:0]        target_seg;
    logic               carry_flag;
    logic               zero_flag;
    logic               sign_flag;
    logic               overflow_flag;
    logic               parity_flag;
    logic [15:0]        count_in;
    logic [2:0]         length;
  } in_word_t;

  // One resolved control transfer.
  typedef struct packed {
    logic [15:0] next_ip;
    logic [15:0] next_cs;
    logic        taken;
    logic [15:0] count_out;
    logic [1:0]  error;
  } out_word_t;

endpackage

// ===== hw/rtl/xbu_if.sv =====
// Valid/ready channel interfaces for the instruction and result words.
interface xbu_in_if;
  logic               valid;
  logic               ready;
  xbu_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface xbu_out_if;
  logic               valid;
  logic               ready;
  xbu_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/xbu_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module xbu_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write and read-first registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/x86_16_branch_unit_top.sv =====
// Top level of the x86 real-mode branch unit.
// The unit resolves one control instruction per clock cycle in steady state
// while the output takes results; an accepted word passes a decode stage that
// addresses the return stack, then a resolve stage that updates IP and CS
// and loads the output register. The return stack is split into two banks
// by entry parity so that a far call can push, and a far return pop, two words
// together; the registered read of those banks sets the two-stage depth, and
// a write that lands on an entry being read for the next word is forwarded, so
// a call followed directly by a return runs at full rate. Overflow and
// underflow are reported in the error field and leave IP, CS and the stack
// unchanged. The stack needs no clearing pass after reset: only pushed entries
// are ever popped, so the unit is ready from the first cycle.
module x86_16_branch_unit_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  xbu_in_if.sink     in_if,
  xbu_out_if.source  out_if
);

  localparam int unsigned SP_W    = xbu_pkg::SP_W;
  localparam int unsigned IDX_W   = xbu_pkg::IDX_W;
  localparam int unsigned BANK_AW = xbu_pkg::BANK_AW;

  // Word held in the resolve stage, with its stack access plan.
  typedef struct packed {
    xbu_pkg::in_word_t          word;
    xbu_pkg::err_e              err;
    logic [1:0]                 wen;
    logic [1:0][BANK_AW-1:0]    waddr;
    logic [1:0]                 wsel_cs;
    logic                       ip_bank;
  } stage_t;

  logic [15:0]             ip_q, cs_q;
  logic [SP_W-1:0]         sp_q, sp_d;
  stage_t                  b_q, a_d;
  logic                    b_valid_q;
  logic                    out_valid_q;
  xbu_pkg::out_word_t      out_data_q, out_d;
  logic                    accept, b_fire;
  logic [1:0][BANK_AW-1:0] raddr_a;
  logic [1:0][15:0]        ram_rdata, rd, wdata;
  logic [1:0]              fwd_q;
  logic [1:0][15:0]        fwd_data_q;
  logic [SP_W-1:0]         e0, e1, em1, em2;
  logic [15:0]             ilen, end_ip, rel_ip, loop_cnt, ip_next, cs_next;
  logic                    taken;

  // Evaluates a jcc condition from the flags.
  function automatic logic cond_holds(input xbu_pkg::in_word_t w);
    logic r;
    case (w.cond[3:1])
      xbu_pkg::CC_O:  r = w.overflow_flag;
      xbu_pkg::CC_C:  r = w.carry_flag;
      xbu_pkg::CC_Z:  r = w.zero_flag;
      xbu_pkg::CC_BE: r = w.carry_flag | w.zero_flag;
      xbu_pkg::CC_S:  r = w.sign_flag;
      xbu_pkg::CC_P:  r = w.parity_flag;
      xbu_pkg::CC_L:  r = w.sign_flag ^ w.overflow_flag;
      default:        r = (w.sign_flag ^ w.overflow_flag) | w.zero_flag;
    endcase
    return w.cond[0] ? ~r : r;
  endfunction

  // Handshake: the resolve stage drains into the output register.
  assign b_fire       = b_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !b_valid_q || b_fire;
  assign accept       = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  // Decode stage: check stack room and plan the bank accesses.
  assign e0  = sp_q;
  assign e1  = sp_q + SP_W'(1);
  assign em1 = sp_q - SP_W'(1);
  assign em2 = sp_q - SP_W'(2);

  always_comb begin
    sp_d          = sp_q;
    a_d.word      = in_if.data;
    a_d.err       = xbu_pkg::ERR_OK;
    a_d.wen       = '0;
    a_d.wsel_cs   = '0;
    a_d.ip_bank   = em1[0];
    for (int k = 0; k < 2; k++) begin
      a_d.waddr[k] = (e0[0] == 1'(k)) ? e0[IDX_W-1:1] : e1[IDX_W-1:1];
      raddr_a[k]   = (em1[0] == 1'(k)) ? em1[IDX_W-1:1] : em2[IDX_W-1:1];
    end
    unique case (in_if.data.func)
      xbu_pkg::FN_CALL_REL16: begin
        if (sp_q < SP_W'(xbu_pkg::STACK_DEPTH)) begin
          a_d.wen[e0[0]] = 1'b1;
          sp_d           = sp_q + SP_W'(1);
        end else begin
          a_d.err = xbu_pkg::ERR_OVERFLOW;
        end
      end
      xbu_pkg::FN_CALL_FAR: begin
        if (sp_q <= SP_W'(xbu_pkg::STACK_DEPTH - 2)) begin
          a_d.wen            = 2'b11;
          a_d.wsel_cs[e0[0]] = 1'b1;
          sp_d               = sp_q + SP_W'(2);
        end else begin
          a_d.err = xbu_pkg::ERR_OVERFLOW;
        end
      end
      xbu_pkg::FN_RET_NEAR: begin
        if (sp_q != '0) begin
          sp_d = em1;
        end else begin
          a_d.err = xbu_pkg::ERR_UNDERFLOW;
        end
      end
      xbu_pkg::FN_RET_FAR: begin
        if (sp_q >= SP_W'(2)) begin
          sp_d = em2;
        end else begin
          a_d.err = xbu_pkg::ERR_UNDERFLOW;
        end
      end
      default: begin
        sp_d = sp_q;
      end
    endcase
  end

  // Return stack banks, even and odd entries.
  for (genvar k = 0; k < 2; k++) begin : g_bank
    xbu_ram #(
      .DEPTH (xbu_pkg::BANK_DEPTH),
      .AW    (BANK_AW),
      .DW    (16)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (b_fire && b_q.wen[k]),
      .waddr_i (b_q.waddr[k]),
      .wdata_i (wdata[k]),
      .re_i    (accept),
      .raddr_i (raddr_a[k]),
      .rdata_o (ram_rdata[k])
    );
    assign rd[k]    = fwd_q[k] ? fwd_data_q[k] : ram_rdata[k];
    assign wdata[k] = b_q.wsel_cs[k] ? cs_q : end_ip;
  end

  // Resolve stage: compute the end of the instruction and the next CS:IP.
  always_comb begin
    unique case (b_q.word.func) inside
      xbu_pkg::FN_JCC, xbu_pkg::FN_JMP_REL8, xbu_pkg::FN_LOOP: ilen = 16'd2;
      xbu_pkg::FN_JMP_REL16, xbu_pkg::FN_CALL_REL16:           ilen = 16'd3;
      xbu_pkg::FN_JMP_FAR, xbu_pkg::FN_CALL_FAR:               ilen = 16'd5;
      xbu_pkg::FN_RET_NEAR, xbu_pkg::FN_RET_FAR:               ilen = 16'd1;
      default:                                                 ilen = 16'(b_q.word.length);
    endcase
  end

  assign end_ip   = ip_q + ilen;
  assign rel_ip   = end_ip + $unsigned(b_q.word.disp);
  assign loop_cnt = b_q.word.count_in - 16'd1;

  always_comb begin
    ip_next = end_ip;
    cs_next = cs_q;
    taken   = 1'b0;
    unique case (b_q.word.func)
      xbu_pkg::FN_JCC: begin
        taken   = cond_holds(b_q.word);
        ip_next = taken ? rel_ip : end_ip;
      end
      xbu_pkg::FN_JMP_REL8, xbu_pkg::FN_JMP_REL16: begin
        taken   = 1'b1;
        ip_next = rel_ip;
      end
      xbu_pkg::FN_JMP_FAR: begin
        taken   = 1'b1;
        ip_next = b_q.word.target_offset;
        cs_next = b_q.word.target_seg;
      end
      xbu_pkg::FN_LOOP: begin
        taken   = (loop_cnt != 16'd0);
        ip_next = taken ? rel_ip : end_ip;
      end
      xbu_pkg::FN_CALL_REL16: begin
        if (b_q.err == xbu_pkg::ERR_OK) begin
          taken   = 1'b1;
          ip_next = rel_ip;
        end else begin
          ip_next = ip_q;
        end
      end
      xbu_pkg::FN_CALL_FAR: begin
        if (b_q.err == xbu_pkg::ERR_OK) begin
          taken   = 1'b1;
          ip_next = b_q.word.target_offset;
          cs_next = b_q.word.target_seg;
        end else begin
          ip_next = ip_q;
        end
      end
      xbu_pkg::FN_RET_NEAR: begin
        if (b_q.err == xbu_pkg::ERR_OK) begin
          taken   = 1'b1;
          ip_next = rd[b_q.ip_bank];
        end else begin
          ip_next = ip_q;
        end
      end
      xbu_pkg::FN_RET_FAR: begin
        if (b_q.err == xbu_pkg::ERR_OK) begin
          taken   = 1'b1;
          ip_next = rd[b_q.ip_bank];
          cs_next = rd[~b_q.ip_bank];
        end else begin
          ip_next = ip_q;
        end
      end
      default: begin
        ip_next = end_ip;
      end
    endcase
    out_d.next_ip   = ip_next;
    out_d.next_cs   = cs_next;
    out_d.taken     = taken;
    out_d.count_out = (b_q.word.func == xbu_pkg::FN_LOOP) ? loop_cnt : b_q.word.count_in;
    out_d.error     = b_q.err;
  end

  // Control state: architectural registers, stack pointer and stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q        <= '0;
      cs_q        <= '0;
      sp_q        <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        sp_q <= sp_d;
      end
      if (b_fire) begin
        ip_q <= ip_next;
        cs_q <= cs_next;
      end
      if (accept) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and write-to-read forwarding into the banks.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_q <= a_d;
      for (int k = 0; k < 2; k++) begin
        fwd_q[k]      <= b_fire && b_q.wen[k] && (b_q.waddr[k] == raddr_a[k]);
        fwd_data_q[k] <= wdata[k];
      end
    end
    if (b_fire) begin
      out_data_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(xbu_pkg::STACK_DEPTH))
    else $error("return stack pointer beyond stack depth");

  a_err_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_fire && (b_q.err != xbu_pkg::ERR_OK) |-> (b_q.wen == 2'b00))
    else $error("stack written by a faulting word");

  a_call_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_if.data.func == xbu_pkg::FN_CALL_REL16)
      && (sp_q < SP_W'(xbu_pkg::STACK_DEPTH))
    |=> sp_q == $past(sp_q) + SP_W'(1))
    else $error("near call did not advance the stack pointer");

  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_fire |=> out_valid_q)
    else $error("resolved word not presented at the output");
`endif

endmodule
